// ===== hw/rtl/epfrs_pkg.sv =====
package epfrs_pkg;

	localparam int unsigned GAIN_W   = 31;
	localparam int unsigned MEAN_W   = 32;
	localparam int unsigned SUM_W    = 48;
	localparam int unsigned WEQ_W    = 44;
	localparam int unsigned TERM_W   = 45;
	localparam int unsigned DIFF_W   = 49;
	localparam int unsigned COR_W    = 41;
	localparam int unsigned CD_W     = 42;
	localparam int unsigned ANG_W    = 16;
	localparam int unsigned BIN_W    = 4;
	localparam int unsigned CENT_W   = 14;
	localparam int unsigned DIV_NW   = 61;
	localparam int unsigned DIV_DW   = 32;
	localparam int unsigned CENTRALITY_BINS = 9;
	localparam int unsigned QSLOTS   = CENTRALITY_BINS * 4;

	localparam logic [GAIN_W-1:0] GAIN_RESET = 31'd409600;
	localparam logic [15:0]       HALF_SQRT2 = 16'd46341;
	localparam logic [CENT_W-1:0] CENT_LIMIT = 14'd8000;
	localparam logic [WEQ_W-1:0]  W_MAX      = {WEQ_W{1'b1}};
	localparam logic [39:0]       COR_MAX    = {40{1'b1}};

	localparam logic [CENT_W-1:0] BIN_EDGE [8] = '{
		14'd500, 14'd1000, 14'd2000, 14'd3000, 14'd4000, 14'd5000, 14'd6000, 14'd7000
	};

	typedef enum logic [1:0] {
		REQ_SAMPLE  = 2'd0,
		REQ_CH_MEAN = 2'd1,
		REQ_Q_MEAN  = 2'd2,
		REQ_Q_WIDTH = 2'd3
	} req_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CH_RD,
		ST_CH_DIV_GO,
		ST_CH_DIV_WAIT,
		ST_CH_ACC,
		ST_CH_END,
		ST_CL_RD,
		ST_CL_DIFF,
		ST_CL_DIV_GO,
		ST_CL_DIV_WAIT,
		ST_CL_NEXT,
		ST_CD_GO,
		ST_CD_WAIT,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		CD_IDLE,
		CD_NORM,
		CD_PREP,
		CD_ROT,
		CD_DONE
	} cd_phase_t;

	// arctangent of 2^-i as a fraction of a full turn (2^32 per turn)
	function automatic logic [31:0] atan_turn(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0:  r = 32'h20000000;
			5'd1:  r = 32'h12E4051E;
			5'd2:  r = 32'h09FB385B;
			5'd3:  r = 32'h051111D4;
			5'd4:  r = 32'h028B0D43;
			5'd5:  r = 32'h0145D7E1;
			5'd6:  r = 32'h00A2F61E;
			5'd7:  r = 32'h00517C55;
			5'd8:  r = 32'h0028BE53;
			5'd9:  r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

	function automatic logic [BIN_W-1:0] cent_bin(input logic [CENT_W-1:0] c);
		logic [BIN_W-1:0] b;
		b = '0;
		for (int e = 0; e < 8; e++) begin
			if (c >= BIN_EDGE[e]) begin
				b = BIN_W'(e + 1);
			end
		end
		return b;
	endfunction

endpackage

// ===== hw/rtl/epfrs_div.sv =====
module epfrs_div #(
	parameter int unsigned NW = 61,
	parameter int unsigned DW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo
);

	localparam int unsigned CW = $clog2(NW + 1);

	logic          run_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [DW:0]   rem_sh;
	logic          ge;
	logic [DW:0]   rem_sub;

	// one quotient bit per cycle, restoring
	always_comb begin
		rem_sh  = {rem_q, quo_q[NW-1]};
		ge      = rem_sh >= {1'b0, den_q};
		rem_sub = rem_sh - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(NW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (run_q) begin
			quo_q <= {quo_q[NW-2:0], ge};
			rem_q <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ===== hw/rtl/epfrs_cordic.sv =====
module epfrs_cordic #(
	parameter int unsigned STEPS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [epfrs_pkg::CD_W-1:0]   x,
	input  logic signed [epfrs_pkg::CD_W-1:0]   y,
	output logic                                done,
	output logic [epfrs_pkg::ANG_W-1:0]         angle
);

	localparam int unsigned IW = (STEPS > 1) ? $clog2(STEPS) : 1;
	localparam int unsigned XW = epfrs_pkg::CD_W + 4;

	epfrs_pkg::cd_phase_t ph_q, ph_nx;

	logic [epfrs_pkg::CD_W-1:0] ax_q, ay_q, m;
	logic                       sx_q, sy_q;
	logic signed [XW-1:0]       x_q, y_q, dx, dy, ys;
	logic [31:0]                z_q, z_rnd;
	logic [IW-1:0]              i_q;

	always_comb begin
		m     = ax_q | ay_q;
		dx    = y_q >>> i_q;
		dy    = x_q >>> i_q;
		ys    = signed'({{(XW - epfrs_pkg::CD_W){1'b0}}, ay_q});
		z_rnd = z_q + 32'h0000_8000;
	end

	always_comb begin
		ph_nx = ph_q;
		case (ph_q)
			epfrs_pkg::CD_IDLE: if (start) ph_nx = epfrs_pkg::CD_NORM;
			epfrs_pkg::CD_NORM: begin
				if (m == '0) begin
					ph_nx = epfrs_pkg::CD_DONE;
				end else if (m[epfrs_pkg::CD_W-1 -: 2] != 2'b00) begin
					ph_nx = epfrs_pkg::CD_PREP;
				end
			end
			epfrs_pkg::CD_PREP: ph_nx = epfrs_pkg::CD_ROT;
			epfrs_pkg::CD_ROT:  if (i_q == IW'(STEPS - 1)) ph_nx = epfrs_pkg::CD_DONE;
			epfrs_pkg::CD_DONE: ph_nx = epfrs_pkg::CD_IDLE;
			default:            ph_nx = epfrs_pkg::CD_IDLE;
		endcase
	end

	always_comb begin
		done  = (ph_q == epfrs_pkg::CD_DONE);
		angle = z_rnd[31:16];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= epfrs_pkg::CD_IDLE;
		end else begin
			ph_q <= ph_nx;
		end
	end

	always_ff @(posedge clk) begin
		case (ph_q)
			epfrs_pkg::CD_IDLE: begin
				ax_q <= x[epfrs_pkg::CD_W-1] ? epfrs_pkg::CD_W'(-x) : x;
				ay_q <= y[epfrs_pkg::CD_W-1] ? epfrs_pkg::CD_W'(-y) : y;
				sx_q <= x[epfrs_pkg::CD_W-1];
				sy_q <= y[epfrs_pkg::CD_W-1];
				z_q  <= '0;
			end
			epfrs_pkg::CD_NORM: begin
				if (m != '0 && m[epfrs_pkg::CD_W-1 -: 2] == 2'b00) begin
					ax_q <= {ax_q[epfrs_pkg::CD_W-2:0], 1'b0};
					ay_q <= {ay_q[epfrs_pkg::CD_W-2:0], 1'b0};
				end
			end
			epfrs_pkg::CD_PREP: begin
				// fold the left half-plane over by half a turn
				x_q <= signed'({{(XW - epfrs_pkg::CD_W){1'b0}}, ax_q});
				y_q <= (sx_q ^ sy_q) ? -ys : ys;
				z_q <= sx_q ? 32'h8000_0000 : 32'h0;
				i_q <= '0;
			end
			epfrs_pkg::CD_ROT: begin
				if (!y_q[XW-1]) begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + epfrs_pkg::atan_turn(5'(i_q));
				end else begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - epfrs_pkg::atan_turn(5'(i_q));
				end
				i_q <= i_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== hw/rtl/event_plane_from_ring_sectors.sv =====
// Second-harmonic event plane from ring-sector multiplicities. Send one word per
// channel sample (tuser = sample) for channels 0..CHANNELS-1; the lower half is
// side C, the upper half side A. Each sample is gain-equalised as
// mult*side_gain/channel_mean (channels with a mean <= 0 are skipped) and added
// to the Q vectors of its side. The sample on channel CHANNELS-1 closes the event
// and yields one result word: three plane angles (value*pi/65536 rad), the
// centrality bin and, in tuser, a valid flag that is low for unknown or
// out-of-range centrality or a zero width in the chosen bin. Calibration tables
// are loaded through the same input stream (tuser = load channel mean, Q mean or
// Q width); loads and out-of-range indexes give no result. Calibration lives in
// three single-port synchronous memories, reset to zero through per-entry valid
// bits, so no clearing pass is needed. One word is worked at a time: a sample
// with a positive mean waits on the 61-step serial divider; a closing sample
// adds up to four recentering divisions and, when no width is zero, three
// CORDIC runs, the normalising shift being one bit a cycle. A finished result
// waits in the output register while the next word is taken.
module event_plane_from_ring_sectors #(
	parameter int unsigned CHANNELS     = 64,
	parameter int unsigned CORDIC_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// config write: index 0 side_c_gain, 1 side_a_gain
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [30:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// tdata: index[5:0], multiplicity[21:6], centrality[35:22],
	//        centrality_known[36], table_value[68:37], zero pad[71:69]
	input  logic [71:0] s_tdata,
	// tuser: req_type[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// tdata: angle_side_a[15:0], angle_side_c[31:16], angle_combined[47:32],
	//        centrality_bin[51:48], zero pad[55:52]
	output logic [55:0] m_tdata,
	// tuser: angles_valid[0]
	output logic        m_tuser
);

	localparam int unsigned CHW = $clog2(CHANNELS);

	// ---- input word fields
	logic [5:0]                      in_idx;
	logic [15:0]                     in_mult;
	logic [epfrs_pkg::CENT_W-1:0]    in_cent;
	logic                            in_known;
	logic [31:0]                     in_word;
	logic                            in_acc;

	assign in_idx   = s_tdata[5:0];
	assign in_mult  = s_tdata[21:6];
	assign in_cent  = s_tdata[35:22];
	assign in_known = s_tdata[36];
	assign in_word  = s_tdata[68:37];
	assign in_acc   = s_tvalid && s_tready;

	// ---- configuration
	logic [epfrs_pkg::GAIN_W-1:0] gain_c_q, gain_a_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_c_q <= epfrs_pkg::GAIN_RESET;
			gain_a_q <= epfrs_pkg::GAIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index) begin
				gain_a_q <= cfg_data;
			end else begin
				gain_c_q <= cfg_data;
			end
		end
	end

	// ---- control
	epfrs_pkg::state_t st_q, st_nx;

	logic                         div_start, div_done, cd_start, cd_done;
	logic                         out_load, q_rd_en;
	logic                         ch_in_range, q_in_range, ch_rd_en;
	logic                         out_vld_q;

	logic [1:0]                   k_q, j_q;
	logic [5:0]                   idx_q;
	logic [15:0]                  mult_q;
	logic [epfrs_pkg::CENT_W-1:0] cent_q;
	logic                         known_q;
	logic                         zw_q, res_vld_q;
	logic [epfrs_pkg::BIN_W-1:0]  bin_q;
	logic                         cent_ok, last_ch, side_a;
	logic                         mean_pos;

	assign ch_in_range = {1'b0, in_idx} < 7'(CHANNELS);
	assign q_in_range  = in_idx < 6'(epfrs_pkg::QSLOTS);
	assign ch_rd_en    = in_acc && s_tuser == epfrs_pkg::REQ_SAMPLE && ch_in_range;
	assign last_ch     = idx_q == 6'(CHANNELS - 1);
	assign side_a      = idx_q >= 6'(CHANNELS / 2);
	assign cent_ok     = known_q && cent_q != '0 && cent_q < epfrs_pkg::CENT_LIMIT;

	// ---- calibration memories
	logic [31:0]          ch_mem [CHANNELS];
	logic [CHANNELS-1:0]  ch_vld_q;
	logic [31:0]          ch_rd_q;
	logic                 ch_rv_q;
	logic [31:0]          qm_mem [epfrs_pkg::QSLOTS];
	logic [31:0]          qw_mem [epfrs_pkg::QSLOTS];
	logic [epfrs_pkg::QSLOTS-1:0] qm_vld_q, qw_vld_q;
	logic [31:0]          qm_rd_q, qw_rd_q;
	logic                 qm_rv_q, qw_rv_q;
	logic [5:0]           q_addr;
	logic [31:0]          mean_eff, qm_eff, qw_eff;

	assign q_addr   = {bin_q, k_q};
	assign mean_eff = ch_rv_q ? ch_rd_q : '0;
	assign qm_eff   = qm_rv_q ? qm_rd_q : '0;
	assign qw_eff   = qw_rv_q ? qw_rd_q : '0;
	assign mean_pos = !mean_eff[31] && mean_eff != '0;

	always_ff @(posedge clk) begin
		if (in_acc && s_tuser == epfrs_pkg::REQ_CH_MEAN && ch_in_range) begin
			ch_mem[in_idx[CHW-1:0]] <= in_word;
		end
		if (ch_rd_en) begin
			ch_rd_q <= ch_mem[in_idx[CHW-1:0]];
		end
		if (in_acc && s_tuser == epfrs_pkg::REQ_Q_MEAN && q_in_range) begin
			qm_mem[in_idx] <= in_word;
		end
		if (in_acc && s_tuser == epfrs_pkg::REQ_Q_WIDTH && q_in_range) begin
			qw_mem[in_idx] <= in_word;
		end
		if (q_rd_en) begin
			qm_rd_q <= qm_mem[q_addr];
			qw_rd_q <= qw_mem[q_addr];
		end
	end

	// entries never loaded read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_vld_q <= '0;
			qm_vld_q <= '0;
			qw_vld_q <= '0;
			ch_rv_q  <= 1'b0;
			qm_rv_q  <= 1'b0;
			qw_rv_q  <= 1'b0;
		end else begin
			if (in_acc && s_tuser == epfrs_pkg::REQ_CH_MEAN && ch_in_range) begin
				ch_vld_q[in_idx[CHW-1:0]] <= 1'b1;
			end
			if (in_acc && s_tuser == epfrs_pkg::REQ_Q_MEAN && q_in_range) begin
				qm_vld_q[in_idx] <= 1'b1;
			end
			if (in_acc && s_tuser == epfrs_pkg::REQ_Q_WIDTH && q_in_range) begin
				qw_vld_q[in_idx] <= 1'b1;
			end
			if (ch_rd_en) begin
				ch_rv_q <= ch_vld_q[in_idx[CHW-1:0]];
			end
			if (q_rd_en) begin
				qm_rv_q <= qm_vld_q[q_addr];
				qw_rv_q <= qw_vld_q[q_addr];
			end
		end
	end

	// ---- shared divider
	logic [epfrs_pkg::DIV_NW-1:0] div_num, div_quo;
	logic [epfrs_pkg::DIV_DW-1:0] div_den;
	logic [46:0]                  prod_q;
	logic signed [epfrs_pkg::DIFF_W-1:0] diff_q;
	logic signed [31:0]           wid_q;
	logic [epfrs_pkg::DIFF_W-1:0] diff_mag;
	logic [31:0]                  wid_mag;

	assign diff_mag = diff_q[epfrs_pkg::DIFF_W-1] ? epfrs_pkg::DIFF_W'(-diff_q)
	                                              : epfrs_pkg::DIFF_W'(diff_q);
	assign wid_mag  = wid_q[31] ? 32'(-wid_q) : 32'(wid_q);

	always_comb begin
		if (st_q == epfrs_pkg::ST_CL_DIV_GO) begin
			div_num = {diff_mag, 12'b0};
			div_den = wid_mag;
		end else begin
			div_num = epfrs_pkg::DIV_NW'({prod_q, 8'b0});
			div_den = mean_eff;
		end
	end

	epfrs_div #(
		.NW (epfrs_pkg::DIV_NW),
		.DW (epfrs_pkg::DIV_DW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	// ---- CORDIC
	logic signed [epfrs_pkg::COR_W-1:0] cor_q [4];
	logic signed [epfrs_pkg::CD_W-1:0]  cd_x, cd_y;
	logic [epfrs_pkg::ANG_W-1:0]        cd_ang;
	logic [epfrs_pkg::ANG_W-1:0]        ang_q [3];

	// pair 0 side A, 1 side C, 2 summed vector
	always_comb begin
		case (j_q)
			2'd0: begin
				cd_x = epfrs_pkg::CD_W'(cor_q[2]);
				cd_y = epfrs_pkg::CD_W'(cor_q[3]);
			end
			2'd1: begin
				cd_x = epfrs_pkg::CD_W'(cor_q[0]);
				cd_y = epfrs_pkg::CD_W'(cor_q[1]);
			end
			default: begin
				cd_x = epfrs_pkg::CD_W'(cor_q[2]) + epfrs_pkg::CD_W'(cor_q[0]);
				cd_y = epfrs_pkg::CD_W'(cor_q[3]) + epfrs_pkg::CD_W'(cor_q[1]);
			end
		endcase
	end

	epfrs_cordic #(
		.STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cd_start),
		.x      (cd_x),
		.y      (cd_y),
		.done   (cd_done),
		.angle  (cd_ang)
	);

	// ---- next state
	always_comb begin
		st_nx = st_q;
		case (st_q)
			epfrs_pkg::ST_IDLE:        if (ch_rd_en) st_nx = epfrs_pkg::ST_CH_RD;
			epfrs_pkg::ST_CH_RD:       st_nx = mean_pos ? epfrs_pkg::ST_CH_DIV_GO
			                                            : epfrs_pkg::ST_CH_END;
			epfrs_pkg::ST_CH_DIV_GO:   st_nx = epfrs_pkg::ST_CH_DIV_WAIT;
			epfrs_pkg::ST_CH_DIV_WAIT: if (div_done) st_nx = epfrs_pkg::ST_CH_ACC;
			epfrs_pkg::ST_CH_ACC:      st_nx = epfrs_pkg::ST_CH_END;
			epfrs_pkg::ST_CH_END: begin
				if (!last_ch) begin
					st_nx = epfrs_pkg::ST_IDLE;
				end else if (cent_ok) begin
					st_nx = epfrs_pkg::ST_CL_RD;
				end else begin
					st_nx = epfrs_pkg::ST_OUT;
				end
			end
			epfrs_pkg::ST_CL_RD:       st_nx = epfrs_pkg::ST_CL_DIFF;
			epfrs_pkg::ST_CL_DIFF:     st_nx = (qw_eff == '0) ? epfrs_pkg::ST_CL_NEXT
			                                                  : epfrs_pkg::ST_CL_DIV_GO;
			epfrs_pkg::ST_CL_DIV_GO:   st_nx = epfrs_pkg::ST_CL_DIV_WAIT;
			epfrs_pkg::ST_CL_DIV_WAIT: if (div_done) st_nx = epfrs_pkg::ST_CL_NEXT;
			epfrs_pkg::ST_CL_NEXT: begin
				if (k_q != 2'd3) begin
					st_nx = epfrs_pkg::ST_CL_RD;
				end else if (zw_q) begin
					st_nx = epfrs_pkg::ST_OUT;
				end else begin
					st_nx = epfrs_pkg::ST_CD_GO;
				end
			end
			epfrs_pkg::ST_CD_GO:       st_nx = epfrs_pkg::ST_CD_WAIT;
			epfrs_pkg::ST_CD_WAIT: begin
				if (cd_done) begin
					st_nx = (j_q == 2'd2) ? epfrs_pkg::ST_OUT : epfrs_pkg::ST_CD_GO;
				end
			end
			epfrs_pkg::ST_OUT:         if (out_load) st_nx = epfrs_pkg::ST_IDLE;
			default:                   st_nx = epfrs_pkg::ST_IDLE;
		endcase
	end

	// ---- control outputs
	always_comb begin
		s_tready  = (st_q == epfrs_pkg::ST_IDLE);
		div_start = (st_q == epfrs_pkg::ST_CH_DIV_GO) || (st_q == epfrs_pkg::ST_CL_DIV_GO);
		cd_start  = (st_q == epfrs_pkg::ST_CD_GO);
		q_rd_en   = (st_q == epfrs_pkg::ST_CL_RD);
		out_load  = (st_q == epfrs_pkg::ST_OUT) && (!out_vld_q || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= epfrs_pkg::ST_IDLE;
		end else begin
			st_q <= st_nx;
		end
	end

	// ---- sample datapath
	logic [epfrs_pkg::WEQ_W-1:0]  w_eq;
	logic [59:0]                  w_prod;
	logic [60:0]                  w_rnd;
	logic [epfrs_pkg::TERM_W-1:0] term_q;
	logic signed [49:0]           t50, acc_x, acc_y;
	logic signed [epfrs_pkg::SUM_W-1:0] sum_x, sum_y, sat_x, sat_y;
	logic signed [epfrs_pkg::SUM_W-1:0] sums_q [4];
	logic                         cos_pos, sin_pos;

	// saturate the equalised value, then weight by sqrt(2)/2 with rounding
	always_comb begin
		w_eq   = (div_quo[epfrs_pkg::DIV_NW-1:epfrs_pkg::WEQ_W] != '0) ? epfrs_pkg::W_MAX
		                                                             : div_quo[epfrs_pkg::WEQ_W-1:0];
		w_prod = w_eq * epfrs_pkg::HALF_SQRT2;
		w_rnd  = {1'b0, w_prod} + 61'd32768;
	end

	always_comb begin
		cos_pos = (idx_q[1:0] == 2'd0) || (idx_q[1:0] == 2'd3);
		sin_pos = !idx_q[1];
		t50     = signed'(50'(term_q));
		sum_x   = side_a ? sums_q[2] : sums_q[0];
		sum_y   = side_a ? sums_q[3] : sums_q[1];
		acc_x   = 50'(sum_x) + (cos_pos ? t50 : -t50);
		acc_y   = 50'(sum_y) + (sin_pos ? t50 : -t50);
		sat_x   = acc_x[48:47] == {2{acc_x[49]}} ? acc_x[47:0]
		        : (acc_x[49] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}});
		sat_y   = acc_y[48:47] == {2{acc_y[49]}} ? acc_y[47:0]
		        : (acc_y[49] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}});
	end

	// ---- recentering
	logic [39:0]                        cor_mag;
	logic signed [epfrs_pkg::COR_W-1:0] cor_val;
	logic                               cor_neg;

	always_comb begin
		cor_mag = (div_quo[epfrs_pkg::DIV_NW-1:40] != '0) ? epfrs_pkg::COR_MAX : div_quo[39:0];
		cor_neg = diff_q[epfrs_pkg::DIFF_W-1] ^ wid_q[31];
		cor_val = cor_neg ? -signed'({1'b0, cor_mag}) : signed'({1'b0, cor_mag});
	end

	// payload: held word, products and results
	always_ff @(posedge clk) begin
		if (in_acc) begin
			idx_q   <= in_idx;
			mult_q  <= in_mult;
			cent_q  <= in_cent;
			known_q <= in_known;
		end
		case (st_q)
			epfrs_pkg::ST_CH_RD:       prod_q <= mult_q * (side_a ? gain_a_q : gain_c_q);
			epfrs_pkg::ST_CH_DIV_WAIT: term_q <= w_rnd[60:16];
			epfrs_pkg::ST_CH_END: begin
				bin_q    <= cent_ok ? epfrs_pkg::cent_bin(cent_q) : '0;
				ang_q[0] <= '0;
				ang_q[1] <= '0;
				ang_q[2] <= '0;
			end
			epfrs_pkg::ST_CL_DIFF: begin
				diff_q <= epfrs_pkg::DIFF_W'(sums_q[k_q]) - epfrs_pkg::DIFF_W'(signed'(qm_eff));
				wid_q  <= qw_eff;
			end
			epfrs_pkg::ST_CL_DIV_WAIT: if (div_done) cor_q[k_q] <= cor_val;
			epfrs_pkg::ST_CD_WAIT:     if (cd_done) ang_q[j_q] <= cd_ang;
			default: begin
			end
		endcase
	end

	// control registers: Q sums, loop counters, flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sums_q[0] <= '0;
			sums_q[1] <= '0;
			sums_q[2] <= '0;
			sums_q[3] <= '0;
			k_q       <= '0;
			j_q       <= '0;
			zw_q      <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			case (st_q)
				epfrs_pkg::ST_CH_ACC: begin
					if (side_a) begin
						sums_q[2] <= sat_x;
						sums_q[3] <= sat_y;
					end else begin
						sums_q[0] <= sat_x;
						sums_q[1] <= sat_y;
					end
				end
				epfrs_pkg::ST_CH_END: begin
					k_q       <= '0;
					j_q       <= '0;
					zw_q      <= 1'b0;
					res_vld_q <= 1'b0;
				end
				epfrs_pkg::ST_CL_DIFF: if (qw_eff == '0) zw_q <= 1'b1;
				epfrs_pkg::ST_CL_NEXT: k_q <= k_q + 1'b1;
				epfrs_pkg::ST_CD_WAIT: begin
					if (cd_done) begin
						j_q <= j_q + 1'b1;
						if (j_q == 2'd2) res_vld_q <= 1'b1;
					end
				end
				epfrs_pkg::ST_OUT: begin
					// drop the event's sums once its result is handed over
					if (out_load) begin
						sums_q[0] <= '0;
						sums_q[1] <= '0;
						sums_q[2] <= '0;
						sums_q[3] <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// ---- output register
	logic [55:0] out_data_q;
	logic        out_user_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {4'b0, bin_q, ang_q[2], ang_q[1], ang_q[0]};
			out_user_q <= res_vld_q;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

`ifndef ASSERT_OFF
	a_invalid_zero_angles: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[47:0] == '0)
		else $error("invalid result carries nonzero angles");

	a_bin_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[51:48] <= 4'd8)
		else $error("centrality bin out of range");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (st_q == epfrs_pkg::ST_CH_DIV_WAIT || st_q == epfrs_pkg::ST_CL_DIV_WAIT))
		else $error("divider finished outside a wait state");

	a_cordic_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		cd_done |-> st_q == epfrs_pkg::ST_CD_WAIT)
		else $error("CORDIC finished outside its wait state");
`endif

endmodule
